// ===== design/mstms_pkg.sv =====
`timescale 1ns / 1ps
// shared constants and beat types for max_subarray_min_times_sum
// no dependencies

package mstms_pkg;

	localparam int unsigned MAX_ITEMS_DEF  = 4096;
	localparam int unsigned VALUE_BITS_DEF = 20;
	localparam int unsigned VALUE_W        = 20;
	localparam int unsigned PREFIX_W       = 32;
	localparam int unsigned BEST_W         = 52;

	typedef struct packed {
		logic [VALUE_W-1:0] value;
		logic               is_last;
	} in_beat_t;

	typedef struct packed {
		logic [BEST_W-1:0] best;
		logic              overflowed;
	} out_beat_t;

endpackage

// ===== design/mstms_ram.sv =====
`timescale 1ns / 1ps
// simple dual-port synchronous ram, one write and one registered read port
// no dependencies

module mstms_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== design/mstms_score.sv =====
`timescale 1ns / 1ps
// product pipeline and running maximum of the scored runs
// depends on mstms_pkg

module mstms_score #(
	parameter int unsigned VALUE_BITS = mstms_pkg::VALUE_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            clr,
	input  logic                            mul_v,
	input  logic [VALUE_BITS-1:0]           mul_a,
	input  logic [mstms_pkg::PREFIX_W-1:0]  mul_b,
	output logic [mstms_pkg::BEST_W-1:0]    best,
	output logic                            busy
);
	import mstms_pkg::*;

	localparam int unsigned PW = VALUE_BITS + PREFIX_W;

	logic [PW-1:0]     full_prod;
	logic [BEST_W-1:0] prod_s2;
	logic              prod_v_s2;
	logic [BEST_W-1:0] best_q;

	assign full_prod = mul_a * mul_b;

	always_ff @(posedge clk) begin
		if (mul_v) begin
			prod_s2 <= BEST_W'(full_prod);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prod_v_s2 <= 1'b0;
			best_q    <= '0;
		end else begin
			prod_v_s2 <= mul_v;
			if (clr) begin
				best_q <= '0;
			end else if (prod_v_s2 && (prod_s2 > best_q)) begin
				best_q <= prod_s2;
			end
		end
	end

	assign best = best_q;
	assign busy = mul_v | prod_v_s2;

endmodule

// ===== design/max_subarray_min_times_sum.sv =====
`timescale 1ns / 1ps
// top level: element store, monotonic stack sequencer and result register
// depends on mstms_pkg, mstms_ram, mstms_score
//
// usage
//   item channel (item_valid / item_stall / item): one element per beat, one beat per
//   cycle while loading. a beat with is_last set closes the sequence; item_stall then
//   stays high while the stack pass runs over the stored elements.
//   result channel (result_valid / result_stall / result): one beat per sequence, holding
//   the best product and the overflow flag. elements past MAX_ITEMS are dropped and flagged.
//   pass: each stored element is read in ST_RD and compared in ST_CMP, and each stack
//   pop runs through ST_CMP and ST_POPW; the pace is set by the registered reads of the
//   element and stack memories, each visited once per step.
//   the result sits in its own register: a new sequence is loaded while it waits, and
//   only the next result waits for result_stall to drop.
//   reset: counters, stack pointers and flags clear at once; memories are not cleared,
//   only entries written for the current sequence are read. no clearing pass.

module max_subarray_min_times_sum #(
	parameter int unsigned MAX_ITEMS  = mstms_pkg::MAX_ITEMS_DEF,
	parameter int unsigned VALUE_BITS = mstms_pkg::VALUE_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 item_valid,
	output logic                 item_stall,
	input  mstms_pkg::in_beat_t  item,
	output logic                 result_valid,
	input  logic                 result_stall,
	output mstms_pkg::out_beat_t result
);
	import mstms_pkg::*;

	localparam int unsigned AW = $clog2(MAX_ITEMS);
	localparam int unsigned CW = $clog2(MAX_ITEMS + 1);
	localparam int unsigned EW = VALUE_BITS + PREFIX_W;

	typedef struct packed {
		logic [VALUE_BITS-1:0] val;
		logic [PREFIX_W-1:0]   pre;
	} entry_t;

	typedef enum logic [4:0] {
		ST_LOAD = 5'b00001,
		ST_RD   = 5'b00010,
		ST_CMP  = 5'b00100,
		ST_POPW = 5'b01000,
		ST_FIN  = 5'b10000
	} state_t;

	state_t          state_q;
	logic [CW-1:0]   count_q;
	logic [CW-1:0]   idx_q;
	logic [CW-1:0]   sdepth_q;
	logic [PREFIX_W-1:0] total_q;
	logic            dropped_q;
	logic            drain_q;
	logic            top_v_q;
	logic            below_v_q;
	logic            below_rd_q;
	entry_t          top_q;
	entry_t          below_q;
	logic [PREFIX_W-1:0] last_pre_q;
	logic            mul_v_s1;
	logic [VALUE_BITS-1:0] mul_a_s1;
	logic [PREFIX_W-1:0]   mul_b_s1;
	out_beat_t       result_q;
	logic            result_valid_q;

	logic            item_acc;
	logic            full;
	logic [VALUE_BITS-1:0] in_val;
	logic [PREFIX_W-1:0]   new_total;
	entry_t          in_entry;
	entry_t          elem;
	entry_t          stk_rdata;
	logic            pop;
	logic            dmem_re;
	logic            stk_we;
	logic            stk_re;
	logic            fin_go;
	logic [BEST_W-1:0] best;
	logic            score_busy;
	logic [EW-1:0]   dmem_rdata_raw;
	logic [EW-1:0]   stk_rdata_raw;

	assign item_stall = (state_q != ST_LOAD);
	assign item_acc   = item_valid & ~item_stall;
	assign full       = (count_q == CW'(MAX_ITEMS));
	assign in_val     = VALUE_BITS'(item.value);
	assign new_total  = total_q + PREFIX_W'(in_val);
	assign in_entry   = '{val: in_val, pre: new_total};

	assign elem      = entry_t'(dmem_rdata_raw);
	assign stk_rdata = entry_t'(stk_rdata_raw);

	assign pop     = top_v_q & (drain_q | (top_q.val >= elem.val));
	assign dmem_re = (state_q == ST_RD) && (idx_q != count_q);
	assign stk_we  = (state_q == ST_CMP) && !pop && !drain_q && below_v_q;
	assign stk_re  = (state_q == ST_CMP) && pop && (sdepth_q != '0);
	assign fin_go  = (state_q == ST_FIN) && !score_busy && (!result_valid_q || !result_stall);

	mstms_ram #(
		.WIDTH (EW),
		.DEPTH (MAX_ITEMS)
	) u_elem_ram (
		.clk   (clk),
		.we    (item_acc && !full),
		.waddr (count_q[AW-1:0]),
		.wdata (in_entry),
		.re    (dmem_re),
		.raddr (idx_q[AW-1:0]),
		.rdata (dmem_rdata_raw)
	);

	mstms_ram #(
		.WIDTH (EW),
		.DEPTH (MAX_ITEMS)
	) u_stack_ram (
		.clk   (clk),
		.we    (stk_we),
		.waddr (sdepth_q[AW-1:0]),
		.wdata (below_q),
		.re    (stk_re),
		.raddr (sdepth_q[AW-1:0] - AW'(1)),
		.rdata (stk_rdata_raw)
	);

	mstms_score #(
		.VALUE_BITS (VALUE_BITS)
	) u_score (
		.clk    (clk),
		.arst_n (arst_n),
		.clr    (fin_go),
		.mul_v  (mul_v_s1),
		.mul_a  (mul_a_s1),
		.mul_b  (mul_b_s1),
		.best   (best),
		.busy   (score_busy)
	);

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_LOAD;
			count_q        <= '0;
			idx_q          <= '0;
			sdepth_q       <= '0;
			total_q        <= '0;
			dropped_q      <= 1'b0;
			drain_q        <= 1'b0;
			top_v_q        <= 1'b0;
			below_v_q      <= 1'b0;
			below_rd_q     <= 1'b0;
			mul_v_s1       <= 1'b0;
			result_valid_q <= 1'b0;
		end else begin
			mul_v_s1 <= 1'b0;
			if (result_valid_q && !result_stall) begin
				result_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_LOAD: begin
					if (item_acc) begin
						if (!full) begin
							total_q <= new_total;
							count_q <= count_q + CW'(1);
						end else begin
							dropped_q <= 1'b1;
						end
						if (item.is_last) begin
							state_q   <= ST_RD;
							idx_q     <= '0;
							sdepth_q  <= '0;
							drain_q   <= 1'b0;
							top_v_q   <= 1'b0;
							below_v_q <= 1'b0;
						end
					end
				end
				ST_RD: begin
					if (idx_q == count_q) begin
						drain_q <= 1'b1;
					end else begin
						idx_q <= idx_q + CW'(1);
					end
					state_q <= ST_CMP;
				end
				ST_CMP: begin
					if (pop) begin
						mul_v_s1   <= 1'b1;
						top_v_q    <= below_v_q;
						below_rd_q <= (sdepth_q != '0);
						if (sdepth_q != '0) begin
							sdepth_q <= sdepth_q - CW'(1);
						end
						state_q <= ST_POPW;
					end else if (drain_q) begin
						state_q <= ST_FIN;
					end else begin
						if (below_v_q) begin
							sdepth_q <= sdepth_q + CW'(1);
						end
						below_v_q <= top_v_q;
						top_v_q   <= 1'b1;
						state_q   <= ST_RD;
					end
				end
				ST_POPW: begin
					below_v_q <= below_rd_q;
					state_q   <= ST_CMP;
				end
				ST_FIN: begin
					if (fin_go) begin
						result_valid_q <= 1'b1;
						count_q        <= '0;
						total_q        <= '0;
						dropped_q      <= 1'b0;
						state_q        <= ST_LOAD;
					end
				end
				default: begin
					state_q <= ST_LOAD;
				end
			endcase
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if ((state_q == ST_CMP) && pop) begin
			mul_a_s1 <= top_q.val;
			mul_b_s1 <= last_pre_q - (below_v_q ? below_q.pre : '0);
			top_q    <= below_q;
		end
		if ((state_q == ST_CMP) && !pop && !drain_q) begin
			below_q    <= top_q;
			top_q      <= elem;
			last_pre_q <= elem.pre;
		end
		if ((state_q == ST_POPW) && below_rd_q) begin
			below_q <= stk_rdata;
		end
		if (fin_go) begin
			result_q <= '{best: best, overflowed: dropped_q};
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

endmodule

// ===== bench/max_subarray_min_times_sum_tb.sv =====
`timescale 1ns / 1ps
// self-checking bench for max_subarray_min_times_sum: directed rows, then random sequences
// depends on mstms_pkg and the max_subarray_min_times_sum top level

module max_subarray_min_times_sum_tb;

	import mstms_pkg::*;

	localparam int unsigned CAPACITY    = MAX_ITEMS_DEF;
	localparam int unsigned CYCLE_LIMIT = 400000;
	localparam int unsigned HOLDOFF_LEN = 3000;
	localparam int unsigned RANDOM_ITEMS = 500;
	localparam logic [VALUE_W-1:0] VALUE_MAX = '1;

	typedef struct packed {
		logic [VALUE_W-1:0] value;
		logic               last;
		logic               pinned;
		logic [BEST_W-1:0]  best;
	} directed_row_t;

	typedef struct {
		bit        pinned;
		out_beat_t answer;
	} pinned_answer_t;

	localparam directed_row_t DIRECTED [0:22] = '{
		'{20'd0,       1'b1, 1'b1, 52'd0},
		'{20'hFFFFF,   1'b1, 1'b1, 52'd1099509530625},
		'{20'hFFFFF,   1'b0, 1'b0, 52'd0},
		'{20'hFFFFF,   1'b1, 1'b1, 52'd2199019061250},
		'{20'd0,       1'b0, 1'b0, 52'd0},
		'{20'd0,       1'b0, 1'b0, 52'd0},
		'{20'd0,       1'b1, 1'b1, 52'd0},
		'{20'd0,       1'b0, 1'b0, 52'd0},
		'{20'd5,       1'b1, 1'b0, 52'd0},
		'{20'd3,       1'b0, 1'b0, 52'd0},
		'{20'd3,       1'b0, 1'b0, 52'd0},
		'{20'd3,       1'b1, 1'b1, 52'd27},
		'{20'd1,       1'b0, 1'b0, 52'd0},
		'{20'd2,       1'b0, 1'b0, 52'd0},
		'{20'd3,       1'b1, 1'b0, 52'd0},
		'{20'd3,       1'b0, 1'b0, 52'd0},
		'{20'd2,       1'b0, 1'b0, 52'd0},
		'{20'd1,       1'b1, 1'b0, 52'd0},
		'{20'hAAAAA,   1'b0, 1'b0, 52'd0},
		'{20'h55555,   1'b1, 1'b0, 52'd0},
		'{20'd7,       1'b0, 1'b0, 52'd0},
		'{20'd0,       1'b0, 1'b0, 52'd0},
		'{20'd7,       1'b1, 1'b1, 52'd49}
	};

	logic      clk = 1'b0;
	logic      arst_n;
	logic      item_valid;
	logic      item_stall;
	in_beat_t  item;
	logic      result_valid;
	logic      result_stall = 1'b0;
	out_beat_t result;

	// sequence collected so far by the predictor
	bit [VALUE_W-1:0]  kept_values[$];
	bit [PREFIX_W-1:0] kept_prefix[$];
	bit [PREFIX_W-1:0] kept_total;
	bit                kept_dropped;

	out_beat_t      expected_results[$];
	pinned_answer_t pinned_answers[$];

	int unsigned failures;
	int unsigned cycle_count;
	int unsigned holdoff_asks;
	int unsigned holdoff_taken;
	int unsigned holdoff_left;
	bit          calm;

	max_subarray_min_times_sum i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// largest product of a value and the sum of its widest run of values not below it
	function automatic bit [BEST_W-1:0] best_min_times_sum();
		int                stack[$];
		int                n;
		int                top;
		int                left;
		bit [PREFIX_W-1:0] span;
		bit [BEST_W-1:0]   prod;
		bit [BEST_W-1:0]   top_best;
		n = kept_values.size();
		top_best = '0;
		for (int i = 0; i <= n; i++) begin
			while (stack.size() > 0 && (i == n || kept_values[stack[$]] >= kept_values[i])) begin
				top = stack.pop_back();
				left = (stack.size() > 0) ? stack[$] + 1 : 0;
				span = kept_prefix[i - 1] - ((left > 0) ? kept_prefix[left - 1] : '0);
				prod = BEST_W'(kept_values[top]) * BEST_W'(span);
				if (prod > top_best) begin
					top_best = prod;
				end
			end
			if (i < n) begin
				stack = {stack, i};
			end
		end
		return top_best;
	endfunction

	task automatic absorb_element(in_beat_t b);
		out_beat_t      predicted;
		pinned_answer_t pin;
		if (kept_values.size() < CAPACITY) begin
			kept_total = kept_total + PREFIX_W'(b.value);
			kept_values = {kept_values, b.value};
			kept_prefix = {kept_prefix, kept_total};
		end else begin
			kept_dropped = 1'b1;
		end
		if (b.is_last) begin
			predicted.best = best_min_times_sum();
			predicted.overflowed = kept_dropped;
			pin = pinned_answers.pop_front();
			expected_results = {expected_results, (pin.pinned ? pin.answer : predicted)};
			kept_values.delete();
			kept_prefix.delete();
			kept_total = '0;
			kept_dropped = 1'b0;
		end
	endtask

	task automatic check_result(out_beat_t got);
		out_beat_t want;
		if (expected_results.size() == 0) begin
			$error("result beat with no expectation: best %0d overflowed %0d",
				got.best, got.overflowed);
			failures++;
		end else begin
			want = expected_results.pop_front();
			if (got.best !== want.best) begin
				$error("best: expected %0d, got %0d", want.best, got.best);
				failures++;
			end
			if (got.overflowed !== want.overflowed) begin
				$error("overflowed: expected %0d, got %0d", want.overflowed, got.overflowed);
				failures++;
			end
		end
	endtask

	always @(posedge clk) begin
		if (arst_n) begin
			if (item_valid && !item_stall) begin
				absorb_element(item);
			end
			if (result_valid && !result_stall) begin
				check_result(result);
			end
		end
	end

	// result side: random stalls, plus a long hold-off on request
	always @(posedge clk) begin
		if (holdoff_left > 0) begin
			result_stall <= 1'b1;
			holdoff_left <= holdoff_left - 1;
		end else if (holdoff_taken != holdoff_asks) begin
			holdoff_taken <= holdoff_asks;
			holdoff_left <= HOLDOFF_LEN;
			result_stall <= 1'b1;
		end else begin
			result_stall <= !calm && ($urandom_range(99) < 19);
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	task automatic send_element(logic [VALUE_W-1:0] v, logic last, bit pinned,
			logic [BEST_W-1:0] best, logic overflowed);
		pinned_answer_t pin;
		if (last) begin
			pin.pinned = pinned;
			pin.answer.best = best;
			pin.answer.overflowed = overflowed;
			pinned_answers = {pinned_answers, pin};
		end
		while (!calm && $urandom_range(99) < 19) begin
			item_valid <= 1'b0;
			@(posedge clk);
		end
		item_valid <= 1'b1;
		item.value <= v;
		item.is_last <= last;
		do @(posedge clk); while (item_stall);
	endtask

	function automatic logic [VALUE_W-1:0] pick_value(int unsigned mode);
		case (mode)
			0: return VALUE_W'($urandom_range(0, 7));
			1: return $urandom_range(0, 1) ? VALUE_MAX : '0;
			2: return VALUE_W'($urandom_range(0, 255));
			default: return VALUE_W'($urandom_range(0, 32'hFFFFF));
		endcase
	endfunction

	initial begin
		int unsigned sent;
		int unsigned seq_index;
		int unsigned len;
		int unsigned mode;
		int unsigned roll;
		arst_n = 1'b0;
		item_valid = 1'b0;
		item = '0;
		failures = 0;
		cycle_count = 0;
		holdoff_asks = 0;
		holdoff_taken = 0;
		holdoff_left = 0;
		calm = 1'b0;
		kept_total = '0;
		kept_dropped = 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (DIRECTED[r]) begin
			send_element(DIRECTED[r].value, DIRECTED[r].last, DIRECTED[r].pinned,
				DIRECTED[r].best, 1'b0);
		end

		sent = 0;
		seq_index = 0;
		while (sent < RANDOM_ITEMS || seq_index <= 30) begin
			roll = $urandom_range(99);
			if (roll < 70) begin
				len = $urandom_range(1, 8);
			end else if (roll < 95) begin
				len = $urandom_range(9, 40);
			end else begin
				len = $urandom_range(41, 200);
			end
			mode = $urandom_range(0, 3);
			calm <= (sent >= 150 && sent < 300);
			if (seq_index == 10) begin
				holdoff_asks <= holdoff_asks + 1;
			end
			if (seq_index == 30) begin
				item_valid <= 1'b0;
				@(posedge clk);
				wait (expected_results.size() == 0);
			end
			for (int i = 0; i < len; i++) begin
				send_element(pick_value(mode), i == len - 1, 1'b0, '0, 1'b0);
			end
			sent += len;
			seq_index++;
		end

		item_valid <= 1'b0;
		calm <= 1'b0;
		@(posedge clk);
		wait (expected_results.size() == 0);
		repeat (64) @(posedge clk);
		if (failures == 0 && expected_results.size() == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule
